### src/psf_pkg.sv
package psf_pkg;
  localparam int Slots = 8;
  localparam int SlotW = $clog2(Slots);
  localparam int BeatBytes = 8;
  localparam int MaxPacketBytes = 2048;
  localparam int WordsPerSlot = MaxPacketBytes / 8;
  localparam int WordW = $clog2(WordsPerSlot);
  localparam int LenW = $clog2(MaxPacketBytes) + 1;
  localparam int CntW = $clog2(Slots) + 1;
  localparam int MemDepth = Slots * WordsPerSlot;
  localparam int AddrW = SlotW + WordW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_IN_RD,
    ST_IN_WR2,
    ST_OUT_RD
  } state_e;

  typedef struct packed {
    logic           acc;
    logic           stored;
    logic           trunc;
    logic           ovalid;
    logic [63:0]    odata;
    logic [7:0]     okeep;
    logic           olast;
    logic [CntW-1:0] queued;
  } result_t;
endpackage

### src/psf_ram.sv
module psf_ram #(
  parameter int Width = 64,
  parameter int Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

### src/psf_ctrl.sv
module psf_ctrl
  import psf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              mode_i,
  input  logic [63:0]       in_data_i,
  input  logic [7:0]        in_keep_i,
  input  logic              in_last_i,
  output logic              busy_o,
  output logic              done_o,
  output result_t           res_o,
  output logic              we_o,
  output logic [AddrW-1:0]  waddr_o,
  output logic [63:0]       wdata_o,
  output logic [AddrW-1:0]  raddr_o,
  input  logic [63:0]       rdata_i
);
  state_e state_q, state_d;
  logic [63:0] data_q, data_d;
  logic [7:0]  keep_q, keep_d;
  logic        last_q, last_d;
  logic [AddrW-1:0]  spill_q, spill_d;
  logic [Slots-1:0]  full_q, full_d;
  logic [LenW-1:0]   slen_q [Slots];
  logic [LenW-1:0]   slen_d;
  logic              slen_we;
  logic [SlotW-1:0]  wslot_q, wslot_d, rslot_q, rslot_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [LenW-1:0]   alen_q, alen_d, soff_q, soff_d;
  logic              aovf_q, aovf_d, sact_q, sact_d;

  // packing of the inbound beat and word merge
  logic [63:0] pk_data;
  logic [3:0]  pk_n;
  logic [LenW:0] room;
  logic [3:0]  take;
  logic [2:0]  bofs;
  logic [127:0] merged, shifted;
  logic [15:0] bmask;
  logic [63:0] lo_word, hi_word;
  logic        two_words;
  logic [LenW:0] new_len;

  // outbound beat fields
  logic [LenW-1:0] len, rem;
  logic [3:0]  nout;
  logic [LenW-1:0] soff_n;
  logic [7:0] okeep;
  logic [63:0] odata;

  always_comb begin
    pk_data = '0;
    pk_n = '0;
    for (int i = 0; i < BeatBytes; i++) begin
      if (keep_q[i]) begin
        pk_data[pk_n[2:0]*8 +: 8] = data_q[i*8 +: 8];
        pk_n = pk_n + 4'd1;
      end
    end
  end

  assign room = (LenW+1)'(MaxPacketBytes) - {1'b0, alen_q};
  assign take = (room < (LenW+1)'(pk_n)) ? room[3:0] : pk_n;
  assign bofs = alen_q[2:0];
  assign new_len = {1'b0, alen_q} + (LenW+1)'(take);
  assign two_words = ({1'b0, bofs} + take) > 4'd8 && (new_len < (LenW+1)'(MaxPacketBytes) ||
                     new_len[2:0] != 3'd0);

  always_comb begin
    bmask = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < take) bmask[i] = 1'b1;
    end
    bmask = bmask << bofs;
    shifted = {64'd0, pk_data} << ({3'd0, bofs} * 7'd8);
    for (int i = 0; i < 8; i++) begin
      merged[i*8 +: 8] = bmask[i] ? shifted[i*8 +: 8] : rdata_i[i*8 +: 8];
    end
    for (int i = 8; i < 16; i++) begin
      merged[i*8 +: 8] = bmask[i] ? shifted[i*8 +: 8] : 8'd0;
    end
    lo_word = merged[63:0];
    hi_word = merged[127:64];
  end

  assign len = slen_q[rslot_q];
  assign rem = len - soff_q;
  assign nout = (rem > LenW'(BeatBytes)) ? 4'(BeatBytes) : rem[3:0];
  assign soff_n = soff_q + LenW'(nout);

  always_comb begin
    okeep = '0;
    odata = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < nout) begin
        okeep[i] = 1'b1;
        odata[i*8 +: 8] = rdata_i[i*8 +: 8];
      end
    end
  end

  // sequencer: read word, then modify and write back or emit
  always_comb begin
    state_d = state_q;
    data_d = data_q; keep_d = keep_q; last_d = last_q; spill_d = spill_q;
    full_d = full_q; wslot_d = wslot_q; rslot_d = rslot_q; cnt_d = cnt_q;
    alen_d = alen_q; aovf_d = aovf_q; sact_d = sact_q; soff_d = soff_q;
    slen_we = 1'b0; slen_d = alen_q;
    done_o = 1'b0; res_o = '0;
    we_o = 1'b0; waddr_o = {wslot_q, alen_q[LenW-2:3]}; wdata_o = lo_word;
    raddr_o = {wslot_q, alen_q[LenW-2:3]};
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          data_d = in_data_i; keep_d = in_keep_i; last_d = in_last_i;
          if (!mode_i) begin
            if (cnt_q < CntW'(Slots)) begin
              state_d = ST_IN_RD;
            end else begin
              done_o = 1'b1;
              res_o.queued = cnt_q - CntW'(sact_q);
            end
          end else begin
            if (!sact_q && cnt_q != '0 && full_q[rslot_q]) begin
              sact_d = 1'b1;
              soff_d = '0;
              raddr_o = {rslot_q, WordW'(0)};
              state_d = ST_OUT_RD;
            end else if (sact_q) begin
              raddr_o = {rslot_q, soff_q[LenW-2:3]};
              state_d = ST_OUT_RD;
            end else begin
              done_o = 1'b1;
              res_o.queued = cnt_q;
            end
          end
        end
      end
      ST_IN_RD: begin
        // merged low word goes back now, bytes past the word end follow in a second write
        we_o = take != '0;
        alen_d = new_len[LenW-1:0];
        if (room < (LenW+1)'(pk_n)) aovf_d = 1'b1;
        state_d = ST_IDLE;
        if (two_words) begin
          data_d = hi_word;
          spill_d = {wslot_q, alen_q[LenW-2:3] + WordW'(1)};
          state_d = ST_IN_WR2;
        end
        res_o.acc = 1'b1;
        if (last_q) begin
          if (new_len != '0) begin
            slen_we = 1'b1;
            slen_d = new_len[LenW-1:0];
            full_d[wslot_q] = 1'b1;
            wslot_d = wslot_q + SlotW'(1);
            cnt_d = cnt_q + CntW'(1);
            res_o.stored = 1'b1;
            res_o.trunc = aovf_q || (room < (LenW+1)'(pk_n));
          end
          alen_d = '0;
          aovf_d = 1'b0;
        end
        res_o.queued = cnt_d - CntW'(sact_q);
        done_o = 1'b1;
      end
      ST_IN_WR2: begin
        // spill bytes start a fresh word, nothing older in it is needed
        we_o = 1'b1;
        waddr_o = spill_q;
        wdata_o = data_q;
        state_d = ST_IDLE;
      end
      ST_OUT_RD: begin
        state_d = ST_IDLE;
        res_o.ovalid = 1'b1;
        res_o.odata = odata;
        res_o.okeep = okeep;
        soff_d = soff_n;
        if (soff_n >= len) begin
          res_o.olast = 1'b1;
          sact_d = 1'b0;
          soff_d = '0;
          full_d[rslot_q] = 1'b0;
          rslot_d = rslot_q + SlotW'(1);
          if (cnt_q != '0) cnt_d = cnt_q - CntW'(1);
        end
        res_o.queued = cnt_d - CntW'(sact_d);
        done_o = 1'b1;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy_o = state_q != ST_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      full_q <= '0; wslot_q <= '0; rslot_q <= '0; cnt_q <= '0;
      alen_q <= '0; aovf_q <= 1'b0; sact_q <= 1'b0; soff_q <= '0;
    end else begin
      state_q <= state_d;
      full_q <= full_d; wslot_q <= wslot_d; rslot_q <= rslot_d; cnt_q <= cnt_d;
      alen_q <= alen_d; aovf_q <= aovf_d; sact_q <= sact_d; soff_q <= soff_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    data_q <= data_d; keep_q <= keep_d; last_q <= last_d; spill_q <= spill_d;
    if (slen_we) slen_q[wslot_q] <= slen_d;
  end
endmodule

### src/packet_store_forward_fifo.sv
// packet_store_forward_fifo: store-and-forward packet queue.
// one command channel: start_i with mode_i, taken when busy_o is low.
// mode 0 offers an inbound beat (in_data_i, in_keep_i, in_last_i);
// mode 1 asks for one outbound beat.
// every request gives one result, marked by done_o for one cycle,
// carrying accepted_o, packet_stored_o, truncated_o, out_* and
// queued_packets_o. a refused request or one with nothing to send gets its
// result in the cycle it is taken and the next request can follow at once.
// a stored or sent beat gets its result in the cycle after it is taken, after
// one packet memory read; busy_o then drops and the next request can be taken.
// when the packed inbound bytes cross a memory word boundary, the spill
// word needs a second write in ST_IN_WR2 and busy_o stays high until it is done.
// reset clears all slot flags, pointers and counters; memory contents are
// not cleared. the receiver cannot stall: results must be taken on done_o.
module packet_store_forward_fifo
  import psf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        mode_i,
  input  logic [63:0] in_data_i,
  input  logic [7:0]  in_keep_i,
  input  logic        in_last_i,
  output logic        done_o,
  output logic        accepted_o,
  output logic        packet_stored_o,
  output logic        truncated_o,
  output logic        out_valid_o,
  output logic [63:0] out_data_o,
  output logic [7:0]  out_keep_o,
  output logic        out_last_o,
  output logic [3:0]  queued_packets_o
);
  result_t res;
  logic we;
  logic [AddrW-1:0] waddr, raddr;
  logic [63:0] wdata, rdata;

  // control and merge logic
  psf_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .mode_i, .in_data_i, .in_keep_i, .in_last_i,
    .busy_o, .done_o, .res_o(res), .we_o(we), .waddr_o(waddr), .wdata_o(wdata),
    .raddr_o(raddr), .rdata_i(rdata)
  );

  // packet storage
  psf_ram #(.Width(64), .Depth(MemDepth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign accepted_o = res.acc;
  assign packet_stored_o = res.stored;
  assign truncated_o = res.trunc;
  assign out_valid_o = res.ovalid;
  assign out_data_o = res.odata;
  assign out_keep_o = res.okeep;
  assign out_last_o = res.olast;
  assign queued_packets_o = res.queued;
endmodule

### src/psf_checker.sv
module psf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       done_o,
  input logic       accepted_o,
  input logic       out_valid_o,
  input logic [7:0] out_keep_o,
  input logic       out_last_o,
  input logic [3:0] queued_packets_o
);
  // a request taken while idle gives a result in the same or the next cycle
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> (done_o or ##1 done_o)) else $error("no result");
  // inbound and outbound results never mix
  a_mix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(accepted_o && out_valid_o)) else $error("mixed result");
  // outbound keep is contiguous from lane 0
  a_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_valid_o) |-> ((out_keep_o & (out_keep_o + 8'd1)) == 8'd0))
    else $error("keep gap");
  // queue never exceeds slot count
  a_q: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> queued_packets_o <= 4'd8) else $error("queue range");
  // a non-last beat is full
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_valid_o && !out_last_o) |-> out_keep_o == 8'hFF)
    else $error("short beat");
endmodule

bind packet_store_forward_fifo psf_checker u_chk (.*);

### bench/packet_store_forward_fifo_tb.sv
`timescale 1ns / 1ps

module packet_store_forward_fifo_tb
  import psf_pkg::*;
();

  localparam logic MODE_IN  = 1'b0;
  localparam logic MODE_OUT = 1'b1;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic        mode_i = MODE_IN;
  logic [63:0] in_data_i = '0;
  logic [7:0]  in_keep_i = '0;
  logic        in_last_i = 1'b0;
  logic        done_o;
  logic        accepted_o;
  logic        packet_stored_o;
  logic        truncated_o;
  logic        out_valid_o;
  logic [63:0] out_data_o;
  logic [7:0]  out_keep_o;
  logic        out_last_o;
  logic [3:0]  queued_packets_o;

  packet_store_forward_fifo dut (.*);

  // clock
  always #1 clk_i = ~clk_i;

  // predictor state
  logic [7:0]      pkt_bytes [Slots][MaxPacketBytes];
  logic [LenW-1:0] pkt_len [Slots];
  logic            pkt_full [Slots];
  int unsigned     wr_slot, rd_slot, used_slots, asm_len, tx_offset;
  logic            asm_over, tx_active;

  result_t     beat_queue [$];
  int unsigned errors = 0;
  int unsigned requests = 0;
  int unsigned results_seen = 0;
  int unsigned packets_stored = 0;
  int unsigned packets_truncated = 0;
  int unsigned refusals = 0;
  int          send_idle_pct = 0;

  // directed table
  typedef struct {
    logic        mode;
    logic [63:0] data;
    logic [7:0]  keep;
    logic        last;
    bit          has_fixed;
    result_t     fixed;
  } dir_row_t;

  dir_row_t dir_rows [$];

  // reports one mismatch
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
  endtask

  // appends one row to the directed table
  task automatic add_row(input logic mode, input logic [63:0] data, input logic [7:0] keep,
                         input logic last, input bit has_fixed, input result_t fixed);
    dir_row_t row;
    row.mode = mode;
    row.data = data;
    row.keep = keep;
    row.last = last;
    row.has_fixed = has_fixed;
    row.fixed = fixed;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // computes the result of one request and advances the predictor
  function automatic result_t predict_beat(input logic mode, input logic [63:0] data,
                                           input logic [7:0] keep, input logic last);
    result_t r;
    int unsigned n;
    r = '0;
    if (mode == MODE_IN) begin
      if (used_slots < Slots) begin
        r.acc = 1'b1;
        for (int i = 0; i < BeatBytes; i++) begin
          if (keep[i]) begin
            if (asm_len < MaxPacketBytes) begin
              pkt_bytes[wr_slot][asm_len] = data[8*i +: 8];
              asm_len++;
            end else begin
              asm_over = 1'b1;
            end
          end
        end
        if (last) begin
          if (asm_len > 0) begin
            pkt_len[wr_slot] = LenW'(asm_len);
            pkt_full[wr_slot] = 1'b1;
            wr_slot = (wr_slot + 1) % Slots;
            used_slots++;
            r.stored = 1'b1;
            r.trunc = asm_over;
          end
          asm_len = 0;
          asm_over = 1'b0;
        end
      end
    end else begin
      if (!tx_active && used_slots > 0 && pkt_full[rd_slot]) begin
        tx_active = 1'b1;
        tx_offset = 0;
      end
      if (tx_active) begin
        n = (pkt_len[rd_slot] > tx_offset) ? pkt_len[rd_slot] - tx_offset : 0;
        if (n > BeatBytes) n = BeatBytes;
        for (int i = 0; i < n; i++) begin
          r.odata[8*i +: 8] = pkt_bytes[rd_slot][tx_offset + i];
          r.okeep[i] = 1'b1;
        end
        r.ovalid = 1'b1;
        tx_offset += n;
        if (tx_offset >= pkt_len[rd_slot]) begin
          r.olast = 1'b1;
          tx_active = 1'b0;
          tx_offset = 0;
          pkt_full[rd_slot] = 1'b0;
          rd_slot = (rd_slot + 1) % Slots;
          if (used_slots > 0) used_slots--;
        end
      end
    end
    r.queued = CntW'(used_slots - (tx_active ? 1 : 0));
    return r;
  endfunction

  // issues one request; has_fixed checks the typed-in result as well
  task automatic send_request(input logic mode, input logic [63:0] data,
                              input logic [7:0] keep, input logic last,
                              input bit has_fixed = 1'b0, input result_t fixed = '0);
    result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    r = predict_beat(mode, data, keep, last);
    if (has_fixed && r != fixed)
      report_mismatch("typed result",
                      64'({r.acc, r.stored, r.trunc, r.ovalid, r.okeep, r.olast, r.queued}),
                      64'({fixed.acc, fixed.stored, fixed.trunc, fixed.ovalid, fixed.okeep,
                           fixed.olast, fixed.queued}));
    if (has_fixed && r.odata != fixed.odata)
      report_mismatch("typed out_data", r.odata, fixed.odata);
    beat_queue.insert(beat_queue.size(), r);
    requests++;
    if (r.stored) packets_stored++;
    if (r.trunc) packets_truncated++;
    if (mode == MODE_IN && !r.acc) refusals++;
    start_i   <= 1'b1;
    mode_i    <= mode;
    in_data_i <= data;
    in_keep_i <= keep;
    in_last_i <= last;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && done_o) begin
      results_seen++;
      if (beat_queue.size() == 0) begin
        report_mismatch("unexpected result", '0, '0);
      end else begin
        want = beat_queue.pop_front();
        if (accepted_o != want.acc)
          report_mismatch("accepted", 64'(accepted_o), 64'(want.acc));
        if (packet_stored_o != want.stored)
          report_mismatch("packet_stored", 64'(packet_stored_o), 64'(want.stored));
        if (truncated_o != want.trunc)
          report_mismatch("truncated", 64'(truncated_o), 64'(want.trunc));
        if (out_valid_o != want.ovalid)
          report_mismatch("out_valid", 64'(out_valid_o), 64'(want.ovalid));
        if (out_data_o != want.odata) report_mismatch("out_data", out_data_o, want.odata);
        if (out_keep_o != want.okeep)
          report_mismatch("out_keep", 64'(out_keep_o), 64'(want.okeep));
        if (out_last_o != want.olast)
          report_mismatch("out_last", 64'(out_last_o), 64'(want.olast));
        if (queued_packets_o != want.queued)
          report_mismatch("queued_packets", 64'(queued_packets_o), 64'(want.queued));
      end
    end
  end

  // random packet with mostly well-formed beats
  task automatic random_packet(input int unsigned nbytes);
    int unsigned left;
    logic [7:0] k;
    left = nbytes;
    while (left > 0 || $urandom_range(9) == 0) begin
      k = ($urandom_range(3) == 0) ? 8'($urandom) : 8'hff;
      left = (left > $countones(k)) ? left - $countones(k) : 0;
      send_request(MODE_IN, {$urandom, $urandom}, k, left == 0);
      if (left == 0) break;
    end
  endtask

  initial begin
    result_t  z, acc_only, full_refuse;
    int unsigned phase_end;
    z = '0;
    acc_only = '0;
    acc_only.acc = 1'b1;
    full_refuse = '0;
    full_refuse.queued = CntW'(Slots);
    wr_slot = 0; rd_slot = 0; used_slots = 0; asm_len = 0; tx_offset = 0;
    asm_over = 1'b0; tx_active = 1'b0;
    foreach (pkt_full[i]) pkt_full[i] = 1'b0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // nothing to send after reset
    add_row(MODE_OUT, 64'hffff_ffff_ffff_ffff, 8'hff, 1'b1, 1'b1, z);
    // empty packet commits nothing
    add_row(MODE_IN, 64'hffff_ffff_ffff_ffff, 8'h00, 1'b1, 1'b1, acc_only);
    // single full beat packet, then short packets with sparse lanes
    add_row(MODE_IN, 64'h0123_4567_89ab_cdef, 8'hff, 1'b1, 1'b0, z);
    add_row(MODE_IN, 64'hffff_ffff_ffff_ffff, 8'h81, 1'b0, 1'b0, z);
    add_row(MODE_IN, 64'h0000_0000_0000_0000, 8'h5a, 1'b0, 1'b0, z);
    add_row(MODE_IN, 64'haaaa_5555_aaaa_5555, 8'hff, 1'b1, 1'b0, z);
    add_row(MODE_IN, 64'h0000_0000_0000_00ff, 8'h01, 1'b1, 1'b0, z);
    // drain with extra requests
    for (int i = 0; i < 6; i++) add_row(MODE_OUT, '0, '0, 1'b0, 1'b0, z);
    // fill all slots
    for (int i = 0; i < Slots; i++)
      add_row(MODE_IN, {8{8'(i + 1)}}, 8'h0f, 1'b1, 1'b0, z);
    // ring full refusal
    add_row(MODE_IN, 64'hffff_ffff_ffff_ffff, 8'hff, 1'b1, 1'b1, full_refuse);
    foreach (dir_rows[i])
      send_request(dir_rows[i].mode, dir_rows[i].data, dir_rows[i].keep, dir_rows[i].last,
                   dir_rows[i].has_fixed, dir_rows[i].fixed);
    while (used_slots > 0) send_request(MODE_OUT, '0, '0, 1'b0);

    // oversize packet: 2048 bytes plus extra, then drain it
    for (int i = 0; i < MaxPacketBytes / 8; i++)
      send_request(MODE_IN, {$urandom, $urandom}, 8'hff, 1'b0);
    send_request(MODE_IN, {$urandom, $urandom}, 8'hff, 1'b1);
    while (used_slots > 0 || tx_active) send_request(MODE_OUT, '0, '0, 1'b0);

    // random phases with different sender idling
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 7 : (ph == 1) ? 86 : 0;
      phase_end = requests + 250;
      while (requests < phase_end) begin
        case ($urandom_range(9))
          0, 1, 2: begin
            random_packet($urandom_range(1, ($urandom_range(19) == 0) ? 300 : 40));
          end
          3: begin
            send_request(MODE_IN, {$urandom, $urandom}, 8'($urandom), 1'($urandom));
          end
          default: begin
            send_request(MODE_OUT, {$urandom, $urandom}, 8'($urandom), 1'($urandom));
          end
        endcase
      end
    end
    start_i <= 1'b0;

    while (beat_queue.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("ran %0d requests, %0d results, %0d packets stored, %0d truncated",
             requests, results_seen, packets_stored, packets_truncated);
    $display("%0d inbound beats refused on a full ring", refusals);
    if (errors == 0 && beat_queue.size() == 0) begin
      $display("packet_store_forward_fifo regression: pass");
    end else begin
      $display("packet_store_forward_fifo regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("packet_store_forward_fifo regression: fail");
    $finish;
  end

endmodule
